// File: rtl/bgp_best_route_select_top_macros.svh
// assertion macros shared by the route select modules
`ifndef BGP_BEST_ROUTE_SELECT_TOP_MACROS_SVH
`define BGP_BEST_ROUTE_SELECT_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BGPRS_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BGPRS_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BGPRS_CHECK(name, prop, msg)
`define BGPRS_NEVER(name, cond, msg)
`endif

`endif

// File: rtl/bgprs_pkg.sv
`timescale 1ns / 1ps
package bgprs_pkg;

  localparam int IDX_W      = 10;
  localparam int ASN_W      = 32;
  localparam int LEN_W      = 8;
  localparam int REL_W      = 3;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 3;
  localparam int KIND_W     = 2;
  localparam int SLOT_LIM_W = 17;
  localparam int RECIP_SH   = 20;
  localparam int JOB_QUEUE_DEPTH = 4;

  localparam logic [CMD_W-1:0] CMD_SEED   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECV   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

  localparam logic [KIND_W-1:0] JOB_REPORT = 2'd0;
  localparam logic [KIND_W-1:0] JOB_SEED   = 2'd1;
  localparam logic [KIND_W-1:0] JOB_RECV   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_ABSORB   = 3'd0;
  localparam logic [STAT_W-1:0] STAT_INSTALL  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_KEPT     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_LOOP     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_SEEDSKIP = 3'd4;
  localparam logic [STAT_W-1:0] STAT_CONFLICT = 3'd5;
  localparam logic [STAT_W-1:0] STAT_SEEDED   = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] prefix_index;
    logic [REL_W-1:0] relationship;
    logic [ASN_W-1:0] hop_asn;
    logic             last_hop;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              entry_valid;
    logic              entry_seeded;
    logic [REL_W-1:0]  best_relationship;
    logic [LEN_W-1:0]  best_path_length;
    logic [ASN_W-1:0]  best_neighbor_asn;
  } out_beat_t;

  typedef struct packed {
    logic             valid;
    logic             seeded;
    logic [REL_W-1:0] rel;
    logic [LEN_W-1:0] len;
    logic [ASN_W-1:0] nbr;
  } route_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  quot;
    logic [REL_W-1:0]  rel;
    logic [LEN_W-1:0]  len;
    logic [ASN_W-1:0]  nbr;
    logic              loop_hit;
  } job_t;

endpackage

// File: rtl/bgprs_ram.sv
`timescale 1ns / 1ps
module bgprs_ram #(
  parameter int WIDTH = 45,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/bgprs_front.sv
`timescale 1ns / 1ps
`include "bgp_best_route_select_top_macros.svh"
module bgprs_front import bgprs_pkg::*; #(
  parameter int PREFIX_SLOTS = 1024,
  parameter int MAX_PATH     = 255
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_beat_t         in_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [ASN_W-1:0] cfg_data,
  input  logic             hold,
  input  logic             q_full,
  output logic             push,
  output job_t             push_job
);

  localparam int PROD_W = IDX_W + RECIP_SH;
  localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((1 << RECIP_SH) / PREFIX_SLOTS);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATH);

  logic [ASN_W-1:0]  own_asn;
  logic [LEN_W-1:0]  hop_count;
  logic [ASN_W-1:0]  first_hop_asn;
  logic [ASN_W-1:0]  second_hop_asn;
  logic              loop_seen;

  logic              accept;
  logic              hop_cmd;
  logic [LEN_W-1:0]  hop_count_next;
  logic [ASN_W-1:0]  first_hop_asn_next;
  logic [ASN_W-1:0]  second_hop_asn_next;
  logic              loop_seen_next;
  logic [PROD_W-1:0] quot_prod;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full && !hold;
  assign accept    = in_valid && in_ready;
  assign push      = accept;

  always_comb begin
    hop_cmd = 1'b0;
    unique case (in_data.command) inside
      CMD_SEED, CMD_RECV:    hop_cmd = 1'b1;
      CMD_LOOKUP, CMD_SPARE: hop_cmd = 1'b0;
    endcase
  end

  assign hop_count_next = (hop_count < MAX_LEN) ? hop_count + LEN_W'(1) : hop_count;
  assign first_hop_asn_next = (hop_count == '0) ? in_data.hop_asn : first_hop_asn;
  assign second_hop_asn_next = (hop_count == LEN_W'(1)) ? in_data.hop_asn : second_hop_asn;
  assign loop_seen_next = loop_seen || (in_data.hop_asn == own_asn);

  // slot quotient by reciprocal, remainder finished in the back part
  assign quot_prod = PROD_W'(in_data.prefix_index) * PROD_W'(RECIP);

  always_comb begin
    push_job.idx      = in_data.prefix_index;
    push_job.quot     = quot_prod[PROD_W-1 -: IDX_W];
    push_job.rel      = in_data.relationship;
    push_job.loop_hit = loop_seen_next;
    push_job.kind     = JOB_REPORT;
    push_job.len      = hop_count_next;
    push_job.nbr      = first_hop_asn_next;
    if (hop_cmd && in_data.last_hop) begin
      if (in_data.command == CMD_SEED) begin
        push_job.kind = JOB_SEED;
        push_job.nbr  = (hop_count_next > LEN_W'(1)) ? second_hop_asn_next
                                                      : first_hop_asn_next;
      end else begin
        push_job.kind = JOB_RECV;
        push_job.len  = (hop_count_next == MAX_LEN) ? MAX_LEN
                                                    : hop_count_next + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_asn        <= '0;
      hop_count      <= '0;
      first_hop_asn  <= '0;
      second_hop_asn <= '0;
      loop_seen      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        own_asn <= cfg_data;
      end
      if (accept && hop_cmd) begin
        if (in_data.last_hop) begin
          hop_count      <= '0;
          first_hop_asn  <= '0;
          second_hop_asn <= '0;
          loop_seen      <= 1'b0;
        end else begin
          hop_count      <= hop_count_next;
          first_hop_asn  <= first_hop_asn_next;
          second_hop_asn <= second_hop_asn_next;
          loop_seen      <= loop_seen_next;
        end
      end
    end
  end

  `BGPRS_CHECK(a_hop_sat, hop_count <= MAX_LEN, "hop count above max path")
  `BGPRS_CHECK(a_path_clear, (accept && hop_cmd && in_data.last_hop) |=> (hop_count == '0), "path not cleared after last hop")

endmodule

// File: rtl/bgprs_queue.sv
`timescale 1ns / 1ps
`include "bgp_best_route_select_top_macros.svh"
module bgprs_queue import bgprs_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + CNT_W'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `BGPRS_NEVER(a_no_overflow, push && full, "job pushed into full queue")

endmodule

// File: rtl/bgprs_back.sv
`timescale 1ns / 1ps
`include "bgp_best_route_select_top_macros.svh"
module bgprs_back import bgprs_pkg::*; #(
  parameter int PREFIX_SLOTS = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  job_t      pop_job,
  output logic      pop,
  output logic      clearing,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int SLOT_W = $clog2(PREFIX_SLOTS);
  localparam int QP_W   = IDX_W + SLOT_LIM_W;
  localparam int ENT_W  = $bits(route_t);
  localparam logic [SLOT_LIM_W-1:0] SLOTS_LIM = SLOT_LIM_W'(PREFIX_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PREFIX_SLOTS - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  logic [1:0]        state;
  logic [SLOT_W-1:0] clr_addr;
  job_t              job_r;
  logic [SLOT_W-1:0] slot_r;

  logic [QP_W-1:0]   qp;
  logic [IDX_W-1:0]  rem;
  logic [IDX_W-1:0]  rem_fix;
  logic [SLOT_W-1:0] slot;
  logic [ENT_W-1:0]  rd_data;
  route_t            cur;
  route_t            fresh;
  route_t            result;
  logic              wins;
  logic              install;
  logic [STAT_W-1:0] status;
  logic              fire;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;

  // slot = prefix_index mod PREFIX_SLOTS, quotient may be one short
  assign qp      = QP_W'(pop_job.quot) * QP_W'(SLOTS_LIM);
  assign rem     = pop_job.idx - qp[IDX_W-1:0];
  assign rem_fix = (SLOT_LIM_W'(rem) >= SLOTS_LIM) ? rem - SLOTS_LIM[IDX_W-1:0] : rem;
  assign slot    = SLOT_W'(rem_fix);

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && !q_empty;
  assign fire     = (state == S_LOOK) && (!out_valid || out_ready);
  assign cur      = route_t'(rd_data);

  always_comb begin
    fresh.valid  = 1'b1;
    fresh.seeded = (job_r.kind == JOB_SEED);
    fresh.rel    = job_r.rel;
    fresh.len    = job_r.len;
    fresh.nbr    = job_r.nbr;
  end

  always_comb begin
    if (!cur.valid) begin
      wins = 1'b1;
    end else if (job_r.rel != cur.rel) begin
      wins = job_r.rel > cur.rel;
    end else if (job_r.len != cur.len) begin
      wins = job_r.len < cur.len;
    end else begin
      wins = job_r.nbr < cur.nbr;
    end
  end

  always_comb begin
    install = 1'b0;
    status  = STAT_ABSORB;
    unique case (job_r.kind)
      JOB_SEED: begin
        if (cur.valid) begin
          status = STAT_CONFLICT;
        end else begin
          install = 1'b1;
          status  = STAT_SEEDED;
        end
      end
      JOB_RECV: begin
        if (cur.valid && cur.seeded) begin
          status = STAT_SEEDSKIP;
        end else if (job_r.loop_hit) begin
          status = STAT_LOOP;
        end else if (wins) begin
          install = 1'b1;
          status  = STAT_INSTALL;
        end else begin
          status = STAT_KEPT;
        end
      end
      default: begin
        install = 1'b0;
        status  = STAT_ABSORB;
      end
    endcase
  end

  assign result = install ? fresh : cur;

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = fire && install;
      ram_waddr = slot_r;
      ram_wdata = ENT_W'(fresh);
    end
  end

  bgprs_ram #(
    .WIDTH(ENT_W),
    .DEPTH(PREFIX_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (pop),
    .raddr(slot),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r  <= pop_job;
      slot_r <= slot;
    end
    if (fire) begin
      out_data.status            <= status;
      out_data.entry_valid       <= result.valid;
      out_data.entry_seeded      <= result.valid && result.seeded;
      out_data.best_relationship <= result.rel;
      out_data.best_path_length  <= result.len;
      out_data.best_neighbor_asn <= result.nbr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + SLOT_W'(1);
          if (clr_addr == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `BGPRS_NEVER(a_clear_quiet, clearing && out_valid, "result offered during table clear")
  `BGPRS_NEVER(a_report_nowrite, fire && ram_we && (job_r.kind == JOB_REPORT), "table written by a report job")
  `BGPRS_CHECK(a_out_after_read, $rose(out_valid) |-> $past(state == S_LOOK), "result without table read")

endmodule

// File: rtl/bgp_best_route_select_top.sv
// channel  dir  signals                                  beat
// in       in   in_valid / in_ready / in_data            one path hop or lookup
// out      out  out_valid / out_ready / out_data         one slot report per item
// cfg      in   cfg_valid / cfg_ready / cfg_data         own_asn write
// after reset the table clear writes all PREFIX_SLOTS slots with in_ready low
// front takes one beat per cycle, while the job queue is not full, into a JOB_QUEUE_DEPTH deep job queue
// back finishes each item in a read then update loop, table read then compare and write back, before the next pop
// out stalls fill the queue and then drop in_ready; cfg_ready is always high
`timescale 1ns / 1ps
module bgp_best_route_select_top import bgprs_pkg::*; #(
  parameter int PREFIX_SLOTS = 1024,
  parameter int MAX_PATH     = 255
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_beat_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [ASN_W-1:0] cfg_data
);

  logic clearing;
  logic push;
  job_t push_job;
  logic q_full;
  logic q_empty;
  logic pop;
  job_t pop_job;

  bgprs_front #(
    .PREFIX_SLOTS(PREFIX_SLOTS),
    .MAX_PATH    (MAX_PATH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .hold     (clearing),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  bgprs_queue #(
    .DEPTH(JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .pop_job (pop_job),
    .empty   (q_empty)
  );

  bgprs_back #(
    .PREFIX_SLOTS(PREFIX_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .pop_job  (pop_job),
    .pop      (pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench import bgprs_pkg::*; ();

  localparam int SLOTS = 1024;
  localparam int MAX_HOPS = 255;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_PRINTS = 100;

  localparam logic [REL_W-1:0] REL_PROVIDER = 3'd1;
  localparam logic [REL_W-1:0] REL_PEER     = 3'd2;
  localparam logic [REL_W-1:0] REL_CUSTOMER = 3'd3;
  localparam logic [REL_W-1:0] REL_ORIGIN   = 3'd4;

  class route_table_tracker;
    route_t           routes [SLOTS];
    logic [ASN_W-1:0] own_asn;
    int unsigned      hop_total;
    logic [ASN_W-1:0] first_asn;
    logic [ASN_W-1:0] second_asn;
    bit               loop_hit;
    out_beat_t        pending_reports [$];
    int               mismatches;
    int               printed;

    function new();
      foreach (routes[i]) routes[i] = '0;
      own_asn = '0;
      hop_total = 0;
      first_asn = '0;
      second_asn = '0;
      loop_hit = 0;
      mismatches = 0;
      printed = 0;
    endfunction

    function void take_beat(in_beat_t b);
      route_t           e;
      out_beat_t        r;
      logic [IDX_W-1:0] slot;
      int unsigned      plen;
      bit               wins;
      slot = IDX_W'(b.prefix_index % SLOTS);
      e = routes[slot];
      r = '0;
      r.status = STAT_ABSORB;
      if (b.command == CMD_SEED || b.command == CMD_RECV) begin
        if (hop_total == 0) first_asn = b.hop_asn;
        else if (hop_total == 1) second_asn = b.hop_asn;
        if (hop_total < MAX_HOPS) hop_total++;
        if (b.hop_asn == own_asn) loop_hit = 1;
        if (b.last_hop) begin
          if (b.command == CMD_SEED) begin
            if (e.valid) begin
              r.status = STAT_CONFLICT;
            end else begin
              e.valid = 1'b1;
              e.seeded = 1'b1;
              e.rel = b.relationship;
              e.len = LEN_W'(hop_total);
              e.nbr = (hop_total > 1) ? second_asn : first_asn;
              r.status = STAT_SEEDED;
            end
          end else if (e.valid && e.seeded) begin
            r.status = STAT_SEEDSKIP;
          end else if (loop_hit) begin
            r.status = STAT_LOOP;
          end else begin
            plen = (hop_total + 1 > MAX_HOPS) ? MAX_HOPS : hop_total + 1;
            if (!e.valid) wins = 1;
            else if (b.relationship != e.rel) wins = b.relationship > e.rel;
            else if (plen != e.len) wins = plen < e.len;
            else wins = first_asn < e.nbr;
            if (wins) begin
              e.valid = 1'b1;
              e.seeded = 1'b0;
              e.rel = b.relationship;
              e.len = LEN_W'(plen);
              e.nbr = first_asn;
              r.status = STAT_INSTALL;
            end else begin
              r.status = STAT_KEPT;
            end
          end
          routes[slot] = e;
          hop_total = 0;
          first_asn = '0;
          second_asn = '0;
          loop_hit = 0;
        end
      end
      if (e.valid) begin
        r.entry_valid = 1'b1;
        r.entry_seeded = e.seeded;
        r.best_relationship = e.rel;
        r.best_path_length = e.len;
        r.best_neighbor_asn = e.nbr;
      end
      pending_reports = {pending_reports, r};
    endfunction

    function void compare(string field, logic [ASN_W-1:0] want, logic [ASN_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        if (printed < MAX_PRINTS) begin
          printed++;
          $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
        end
      end
    endfunction

    function void check_report(out_beat_t got);
      out_beat_t want;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (printed < MAX_PRINTS) begin
          printed++;
          $display("%0t: unexpected report, expected none actual %h", $time, got);
        end
        return;
      end
      want = pending_reports.pop_front();
      compare("status", ASN_W'(want.status), ASN_W'(got.status));
      compare("entry_valid", ASN_W'(want.entry_valid), ASN_W'(got.entry_valid));
      compare("entry_seeded", ASN_W'(want.entry_seeded), ASN_W'(got.entry_seeded));
      compare("best_relationship", ASN_W'(want.best_relationship),
              ASN_W'(got.best_relationship));
      compare("best_path_length", ASN_W'(want.best_path_length),
              ASN_W'(got.best_path_length));
      compare("best_neighbor_asn", want.best_neighbor_asn, got.best_neighbor_asn);
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_beat_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [ASN_W-1:0] cfg_data;

  route_table_tracker tracker = new();
  bit tx_steady;
  bit rx_steady;
  int beats_sent;
  int idle_cycles;
  int unsigned hot_slots [16];

  bgp_best_route_select_top #(
    .PREFIX_SLOTS(SLOTS),
    .MAX_PATH    (MAX_HOPS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_slot();
    if ($urandom_range(0, 4) != 0) return hot_slots[4'($urandom_range(0, 15))];
    return $urandom_range(0, SLOTS - 1);
  endfunction

  function automatic logic [ASN_W-1:0] pick_asn();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return tracker.own_asn;
    if (r < 70) return $urandom_range(1, 24);
    if (r < 75) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return $urandom;
  endfunction

  // receiver side stalls
  initial begin
    int stall_left;
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_report(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_beat(in_beat_t b);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.take_beat(b);
    beats_sent++;
  endtask

  task automatic send_hop(logic [CMD_W-1:0] cmd, int unsigned slot, logic [REL_W-1:0] rel,
                          logic [ASN_W-1:0] asn, bit last);
    in_beat_t b;
    b.command = cmd;
    b.prefix_index = IDX_W'(slot);
    b.relationship = rel;
    b.hop_asn = asn;
    b.last_hop = last;
    send_beat(b);
  endtask

  task automatic wait_for_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_own_asn(logic [ASN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    tracker.own_asn = value;
  endtask

  task automatic send_long_path(logic [CMD_W-1:0] cmd, int unsigned slot,
                                logic [REL_W-1:0] rel, int hops, int loop_at);
    logic [ASN_W-1:0] asn;
    for (int i = 0; i < hops; i++) begin
      asn = (i == loop_at) ? tracker.own_asn : $urandom_range(100000, 200000);
      send_hop(cmd, slot, rel, asn, i == hops - 1);
    end
  endtask

  task automatic send_random_path();
    in_beat_t         b;
    int               kind;
    int               hops;
    logic [CMD_W-1:0] cmd;
    int unsigned      slot;
    logic [REL_W-1:0] rel;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      b.command = CMD_W'($urandom_range(0, 3));
      b.prefix_index = IDX_W'($urandom_range(0, SLOTS - 1));
      b.relationship = REL_W'($urandom_range(0, 7));
      b.hop_asn = $urandom;
      b.last_hop = 1'($urandom_range(0, 1));
      send_beat(b);
    end else if (kind < 22) begin
      cmd = ($urandom_range(0, 3) == 0) ? CMD_SPARE : CMD_LOOKUP;
      send_hop(cmd, pick_slot(), REL_W'($urandom_range(0, 7)), $urandom,
               1'($urandom_range(0, 1)));
    end else begin
      cmd = ($urandom_range(0, 99) < 8) ? CMD_SEED : CMD_RECV;
      if (cmd == CMD_SEED && $urandom_range(0, 4) != 0) slot = $urandom_range(0, SLOTS - 1);
      else slot = pick_slot();
      if ($urandom_range(0, 19) == 0) rel = REL_W'($urandom_range(0, 7));
      else rel = REL_W'($urandom_range(REL_PROVIDER, REL_ORIGIN));
      hops = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 8);
      for (int i = 0; i < hops; i++) send_hop(cmd, slot, rel, pick_asn(), i == hops - 1);
    end
  endtask

  task automatic run_random(int count);
    int target;
    target = beats_sent + count;
    while (beats_sent < target) begin
      if ($urandom_range(0, 39) == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      send_random_path();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    tx_steady = 0;
    rx_steady = 0;
    beats_sent = 0;
    foreach (hot_slots[i]) hot_slots[i] = $urandom_range(16, 1000);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_own_asn(32'd65000);
    send_hop(CMD_LOOKUP, 0, REL_PROVIDER, '0, 1'b0);
    send_hop(CMD_SEED, 0, REL_ORIGIN, '1, 1'b1);
    send_hop(CMD_SEED, SLOTS - 1, REL_ORIGIN, 32'd100, 1'b0);
    send_hop(CMD_SEED, SLOTS - 1, REL_ORIGIN, 32'd200, 1'b1);
    // occupied slot, then received path into a seeded slot that also loops
    send_hop(CMD_SEED, SLOTS - 1, REL_PEER, 32'd7, 1'b1);
    send_hop(CMD_RECV, SLOTS - 1, REL_CUSTOMER, 32'd65000, 1'b1);
    send_hop(CMD_RECV, 5, REL_PROVIDER, 32'd65000, 1'b1);
    send_hop(CMD_RECV, 5, REL_PROVIDER, 32'd300, 1'b0);
    send_hop(CMD_RECV, 5, REL_PROVIDER, 32'd400, 1'b1);
    send_hop(CMD_RECV, 5, REL_PEER, 32'd500, 1'b1);
    send_hop(CMD_RECV, 5, REL_PROVIDER, 32'd100, 1'b1);
    send_hop(CMD_RECV, 5, REL_PEER, 32'd50, 1'b0);
    send_hop(CMD_RECV, 5, REL_PEER, 32'd60, 1'b1);
    send_hop(CMD_RECV, 5, REL_PEER, 32'd499, 1'b1);
    send_hop(CMD_RECV, 5, REL_PEER, 32'd499, 1'b1);
    // mixed path with a spare command in the middle and a raw relationship
    send_hop(CMD_SEED, 9, REL_ORIGIN, 32'd700, 1'b0);
    send_hop(CMD_SPARE, 5, 3'd7, '1, 1'b1);
    send_hop(CMD_RECV, 9, 3'd7, 32'd800, 1'b1);
    send_hop(CMD_RECV, 9, 3'd0, 32'd1, 1'b1);
    wait_for_reports();

    write_own_asn('0);
    send_hop(CMD_RECV, 7, REL_PEER, '0, 1'b1);
    send_hop(CMD_RECV, 7, REL_PEER, 32'd1, 1'b1);
    wait_for_reports();

    write_own_asn('1);
    run_random(50);
    send_long_path(CMD_RECV, 1010, REL_CUSTOMER, 256, -1);
    run_random(50);
    wait_for_reports();

    write_own_asn($urandom);
    run_random(50);
    wait_for_reports();
    run_random(40);
    wait_for_reports();

    write_own_asn($urandom_range(1, 24));
    run_random(30);
    send_long_path(CMD_RECV, 1012, REL_PEER, 257, 256);
    run_random(30);
    wait_for_reports();

    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
